// File: hw/rtl/tapd_pkg.sv
// Shared types and constants for the accelerometer tap detector.
package tapd_pkg;

  localparam int HISTORY_DEPTH = 8;

  localparam int SAMPLE_W = 16;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int TIME_W   = 64;
  localparam int TCFG_W   = 32;
  localparam int THR_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_REJECTION_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_THR    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSION_THR  = 2'd3;

  localparam logic [TCFG_W-1:0] REJECTION_TIME_RST = 32'd70000;
  localparam logic [TCFG_W-1:0] DOUBLE_WINDOW_RST  = 32'd300000;
  localparam logic [THR_W-1:0]  TRIGGER_THR_RST    = 16'd2048;
  localparam logic [THR_W-1:0]  INVERSION_THR_RST  = 16'd3686;

  localparam logic KIND_SINGLE = 1'b0;
  localparam logic KIND_DOUBLE = 1'b1;
  localparam logic POL_POS     = 1'b0;
  localparam logic POL_NEG     = 1'b1;

  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef struct packed {
    logic ge_inv;
    logic le_neg_inv;
  } inv_flags_t;

  typedef struct packed {
    logic tap_found;
    logic tap_kind;
    logic tap_polarity;
  } tap_result_t;

endpackage

// File: hw/rtl/tapd_in_if.sv
// Input channel: one sample and its timestamp per beat.
interface tapd_in_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   sample;
  logic        [63:0]   time_us;

  modport source (output valid, output sample, output time_us, input ready);
  modport sink   (input valid, input sample, input time_us, output ready);
endinterface

// File: hw/rtl/tapd_out_if.sv
// Result channel: one tap report per beat.
interface tapd_out_if;
  logic valid;
  logic ready;
  logic tap_found;
  logic tap_kind;
  logic tap_polarity;

  modport source (output valid, output tap_found, output tap_kind, output tap_polarity,
                  input ready);
  modport sink   (input valid, input tap_found, input tap_kind, input tap_polarity,
                  output ready);
endinterface

// File: hw/rtl/tapd_cell.sv
// History cell: holds one difference, shifts it on, flags inversion crossings.
module tapd_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift_en,
  input  tapd_pkg::diff_t            d_in,
  input  logic [tapd_pkg::THR_W-1:0] inv_thr,
  output tapd_pkg::diff_t            d_out,
  output tapd_pkg::inv_flags_t       flags
);
  import tapd_pkg::*;

  diff_t d_r;
  diff_t d_nxt;
  logic signed [DIFF_W:0] d_ext;
  logic signed [DIFF_W:0] thr_ext;

  always_comb begin
    d_ext   = {d_in[DIFF_W-1], d_in};
    thr_ext = {{(DIFF_W+1-THR_W){1'b0}}, inv_thr};
    flags.ge_inv     = (d_ext >= thr_ext);
    flags.le_neg_inv = ((d_ext + thr_ext) <= $signed({(DIFF_W+1){1'b0}}));
    d_nxt = shift_en ? d_in : d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= '0;
    end else begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;
endmodule

// File: hw/rtl/tapd_ctrl.sv
// Tap decision: dead time, window expiry, trigger and pending tap tracking.
module tapd_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic signed [tapd_pkg::SAMPLE_W-1:0] sample,
  input  logic [tapd_pkg::TIME_W-1:0] time_us,
  input  logic [tapd_pkg::TCFG_W-1:0] rejection_time,
  input  logic [tapd_pkg::TCFG_W-1:0] double_window,
  input  logic [tapd_pkg::THR_W-1:0]  trigger_thr,
  input  tapd_pkg::inv_flags_t        any_inv,
  output tapd_pkg::diff_t             new_diff,
  output tapd_pkg::tap_result_t       result
);
  import tapd_pkg::*;

  logic signed [SAMPLE_W-1:0] last_sample_r, last_sample_nxt;
  logic [TIME_W-1:0]          last_tap_r, last_tap_nxt;
  logic                       pending_r, pending_nxt;
  logic                       pend_pol_r, pend_pol_nxt;

  logic [TIME_W-1:0]      elapsed;
  logic                   dead;
  logic                   expire;
  logic signed [DIFF_W:0] d_ext;
  logic signed [DIFF_W:0] trig_ext;
  logic                   trig_pos;
  logic                   trig_neg;
  logic                   tap_seen;
  logic                   tap_pol;

  always_comb begin
    new_diff = DIFF_W'({sample[SAMPLE_W-1], sample}) -
               DIFF_W'({last_sample_r[SAMPLE_W-1], last_sample_r});
    d_ext    = {new_diff[DIFF_W-1], new_diff};
    trig_ext = {{(DIFF_W+1-THR_W){1'b0}}, trigger_thr};
    trig_pos = (d_ext >= trig_ext);
    trig_neg = ((d_ext + trig_ext) <= $signed({(DIFF_W+1){1'b0}}));
    tap_seen = trig_pos || trig_neg;
    if (trig_pos) begin
      tap_pol = any_inv.le_neg_inv ? POL_NEG : POL_POS;
    end else begin
      tap_pol = any_inv.ge_inv ? POL_POS : POL_NEG;
    end

    elapsed = time_us - last_tap_r;
    dead    = (elapsed < {{(TIME_W-TCFG_W){1'b0}}, rejection_time});
    expire  = pending_r && (elapsed > {{(TIME_W-TCFG_W){1'b0}}, double_window});

    last_sample_nxt = sample;
    last_tap_nxt    = last_tap_r;
    pending_nxt     = pending_r;
    pend_pol_nxt    = pend_pol_r;
    result          = '0;

    if (!dead) begin
      if (expire) begin
        pending_nxt         = 1'b0;
        result.tap_found    = 1'b1;
        result.tap_kind     = KIND_SINGLE;
        result.tap_polarity = pend_pol_r;
      end else if (tap_seen) begin
        last_tap_nxt = time_us;
        if (!pending_r) begin
          pending_nxt  = 1'b1;
          pend_pol_nxt = tap_pol;
        end else begin
          pending_nxt = 1'b0;
          if (tap_pol == pend_pol_r) begin
            result.tap_found    = 1'b1;
            result.tap_kind     = KIND_DOUBLE;
            result.tap_polarity = pend_pol_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r <= '0;
      last_tap_r    <= '0;
      pending_r     <= 1'b0;
      pend_pol_r    <= POL_POS;
    end else if (step_en) begin
      last_sample_r <= last_sample_nxt;
      last_tap_r    <= last_tap_nxt;
      pending_r     <= pending_nxt;
      pend_pol_r    <= pend_pol_nxt;
    end
  end
endmodule

// File: hw/rtl/tapd_skid.sv
// Two-entry output buffer between the decision logic and the result channel.
module tapd_skid (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tapd_pkg::tap_result_t push_data,
  output logic                  can_push,
  tapd_out_if.source            out_bus
);
  import tapd_pkg::*;

  tap_result_t slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pop;
  tap_result_t head;

  always_comb begin
    can_push   = (cnt_r != 2'd2);
    pop        = (cnt_r != 2'd0) && out_bus.ready;
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
    head       = slot_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_bus.valid        = (cnt_r != 2'd0);
  assign out_bus.tap_found    = head.tap_found;
  assign out_bus.tap_kind     = head.tap_kind;
  assign out_bus.tap_polarity = head.tap_polarity;
endmodule

// File: hw/rtl/accel_tap_detector_top.sv
// Top level of the accelerometer single and double tap detector.
// Each accepted beat's result enters a two-entry buffer that absorbs a stalled result.
// Throughput: one sample per cycle while the output buffer is not full.
// The whole decision (difference, history compares, 64-bit elapsed time) is combinational.
// Reset (rst_n low at a clock edge) clears history, pending tap, buffer and
// restores the register defaults.
module accel_tap_detector_top (
  input  logic                            clk,
  input  logic                            rst_n,
  tapd_in_if.sink                         in_bus,
  tapd_out_if.source                      out_bus,
  input  logic                            cfg_we,
  input  logic [tapd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tapd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tapd_pkg::*;

  logic [TCFG_W-1:0] rej_r, rej_nxt;
  logic [TCFG_W-1:0] win_r, win_nxt;
  logic [THR_W-1:0]  trig_r, trig_nxt;
  logic [THR_W-1:0]  inv_r, inv_nxt;

  logic        accept;
  logic        can_push;
  diff_t       new_diff;
  diff_t       chain [HISTORY_DEPTH];
  inv_flags_t  cell_flags [HISTORY_DEPTH];
  inv_flags_t  any_inv;
  tap_result_t result;

  always_comb begin
    rej_nxt  = rej_r;
    win_nxt  = win_r;
    trig_nxt = trig_r;
    inv_nxt  = inv_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_REJECTION_TIME: rej_nxt  = cfg_wdata[TCFG_W-1:0];
        REG_DOUBLE_WINDOW:  win_nxt  = cfg_wdata[TCFG_W-1:0];
        REG_TRIGGER_THR:    trig_nxt = cfg_wdata[THR_W-1:0];
        REG_INVERSION_THR:  inv_nxt  = cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rej_r  <= REJECTION_TIME_RST;
      win_r  <= DOUBLE_WINDOW_RST;
      trig_r <= TRIGGER_THR_RST;
      inv_r  <= INVERSION_THR_RST;
    end else begin
      rej_r  <= rej_nxt;
      win_r  <= win_nxt;
      trig_r <= trig_nxt;
      inv_r  <= inv_nxt;
    end
  end

  assign in_bus.ready = can_push;
  assign accept       = in_bus.valid && can_push;
  assign chain[0]     = new_diff;

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    if (i < HISTORY_DEPTH - 1) begin : g_mid
      tapd_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (accept),
        .d_in     (chain[i]),
        .inv_thr  (inv_r),
        .d_out    (chain[i+1]),
        .flags    (cell_flags[i])
      );
    end else begin : g_last
      tapd_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (accept),
        .d_in     (chain[i]),
        .inv_thr  (inv_r),
        .d_out    (),
        .flags    (cell_flags[i])
      );
    end
  end

  always_comb begin
    any_inv = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      any_inv.ge_inv     = any_inv.ge_inv     | cell_flags[i].ge_inv;
      any_inv.le_neg_inv = any_inv.le_neg_inv | cell_flags[i].le_neg_inv;
    end
  end

  tapd_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (accept),
    .sample         (in_bus.sample),
    .time_us        (in_bus.time_us),
    .rejection_time (rej_r),
    .double_window  (win_r),
    .trigger_thr    (trig_r),
    .any_inv        (any_inv),
    .new_diff       (new_diff),
    .result         (result)
  );

  tapd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .can_push  (can_push),
    .out_bus   (out_bus)
  );

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_bus.valid)
    else $error("accepted beat produced no result");

  a_kind_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.tap_found |-> !out_bus.tap_kind && !out_bus.tap_polarity)
    else $error("empty report carries kind or polarity");

  a_full_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> out_bus.valid)
    else $error("input stalled with empty output buffer");

  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cfg_we) && $past(rst_n) |-> $stable(trig_r) && $stable(rej_r))
    else $error("register changed without a write");
endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the accelerometer tap detector top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tapd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int BEATS_PER_PHASE = 185;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic [TIME_W-1:0]          t_us;
  } sample_beat_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tapd_in_if  in_bus();
  tapd_out_if out_bus();

  accel_tap_detector_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // detector copy: settings and state
  logic [TCFG_W-1:0] cfg_rej_us  = REJECTION_TIME_RST;
  logic [TCFG_W-1:0] cfg_win_us  = DOUBLE_WINDOW_RST;
  logic [THR_W-1:0]  cfg_trig    = TRIGGER_THR_RST;
  logic [THR_W-1:0]  cfg_inv     = INVERSION_THR_RST;
  logic signed [SAMPLE_W-1:0] prev_sample = '0;
  diff_t             diff_hist [HISTORY_DEPTH];
  logic [TIME_W-1:0] last_tap_us = '0;
  logic              tap_armed   = 1'b0;
  logic              armed_pol   = POL_POS;

  sample_beat_t beat_q[$];
  tap_result_t  pending_reports[$];
  logic         in_took = 1'b0;
  int           mismatch_cnt = 0;
  int           idle_cycles = 0;
  int           hold_req = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  logic         no_idle = 1'b0;
  int           gen_last = 0;
  logic [TIME_W-1:0] gen_now = '0;

  initial begin
    for (int i = 0; i < HISTORY_DEPTH; i++) diff_hist[i] = '0;
  end

  function automatic tap_result_t tap_predict(input logic signed [SAMPLE_W-1:0] smp,
                                              input logic [TIME_W-1:0] now);
    tap_result_t res;
    logic [TIME_W-1:0] elapsed;
    int d0;
    int trig;
    int inv;
    logic seen;
    logic pol;
    res = '0;
    for (int i = HISTORY_DEPTH - 1; i > 0; i--) diff_hist[i] = diff_hist[i-1];
    diff_hist[0] = $signed({smp[SAMPLE_W-1], smp}) -
                   $signed({prev_sample[SAMPLE_W-1], prev_sample});
    prev_sample = smp;
    elapsed = now - last_tap_us;
    if (elapsed < {32'd0, cfg_rej_us}) return res;
    if (tap_armed && elapsed > {32'd0, cfg_win_us}) begin
      tap_armed = 1'b0;
      res.tap_found = 1'b1;
      res.tap_kind = KIND_SINGLE;
      res.tap_polarity = armed_pol;
      return res;
    end
    d0 = int'(diff_hist[0]);
    trig = int'(cfg_trig);
    inv = int'(cfg_inv);
    seen = 1'b0;
    pol = POL_POS;
    if (d0 >= trig) begin
      seen = 1'b1;
      for (int i = 0; i < HISTORY_DEPTH; i++)
        if (int'(diff_hist[i]) <= -inv) pol = POL_NEG;
    end else if (d0 <= -trig) begin
      seen = 1'b1;
      pol = POL_NEG;
      for (int i = 0; i < HISTORY_DEPTH; i++)
        if (int'(diff_hist[i]) >= inv) pol = POL_POS;
    end
    if (seen) begin
      last_tap_us = now;
      if (!tap_armed) begin
        tap_armed = 1'b1;
        armed_pol = pol;
      end else begin
        tap_armed = 1'b0;
        if (pol == armed_pol) begin
          res.tap_found = 1'b1;
          res.tap_kind = KIND_DOUBLE;
          res.tap_polarity = armed_pol;
        end
      end
    end
    return res;
  endfunction

  // sample handshakes, predict, check results, watchdog
  always @(posedge clk) begin
    tap_result_t want;
    tap_result_t got;
    logic in_fire;
    logic out_fire;
    in_fire = rst_n && in_bus.valid && in_bus.ready;
    out_fire = rst_n && out_bus.valid && out_bus.ready;
    in_took <= in_fire;
    if (in_fire) pending_reports.push_back(tap_predict(in_bus.sample, in_bus.time_us));
    if (out_fire) begin
      got = {out_bus.tap_found, out_bus.tap_kind, out_bus.tap_polarity};
      if (pending_reports.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("%0t: unexpected beat found=%b kind=%b pol=%b", $time,
                   got.tap_found, got.tap_kind, got.tap_polarity);
        mismatch_cnt++;
      end else begin
        want = pending_reports.pop_front();
        if (got.tap_found !== want.tap_found || got.tap_kind !== want.tap_kind ||
            got.tap_polarity !== want.tap_polarity) begin
          if (mismatch_cnt < 10)
            $display("%0t: mismatch found=%b/%b kind=%b/%b pol=%b/%b (expected/actual)",
                     $time, want.tap_found, got.tap_found, want.tap_kind, got.tap_kind,
                     want.tap_polarity, got.tap_polarity);
          mismatch_cnt++;
        end
      end
    end
    idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // sample driver
  always @(negedge clk) begin
    sample_beat_t nxt;
    if (!(in_bus.valid && !in_took)) begin
      if (beat_q.size() != 0 && (no_idle || $urandom_range(99, 0) >= 31)) begin
        nxt = beat_q.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.sample <= nxt.smp;
        in_bus.time_us <= nxt.t_us;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      out_bus.ready <= 1'b0;
      hold_left <= HOLD_OFF_CYCLES;
      hold_seen <= hold_seen + 1;
    end else begin
      out_bus.ready <= no_idle || ($urandom_range(99, 0) >= 31);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      REG_REJECTION_TIME: cfg_rej_us = data[TCFG_W-1:0];
      REG_DOUBLE_WINDOW:  cfg_win_us = data[TCFG_W-1:0];
      REG_TRIGGER_THR:    cfg_trig = data[THR_W-1:0];
      REG_INVERSION_THR:  cfg_inv = data[THR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_setting(input logic [TCFG_W-1:0] rej, input logic [TCFG_W-1:0] win,
                               input logic [THR_W-1:0] trig, input logic [THR_W-1:0] inv);
    write_reg(REG_REJECTION_TIME, rej);
    write_reg(REG_DOUBLE_WINDOW, win);
    write_reg(REG_TRIGGER_THR, {16'($urandom), trig});
    write_reg(REG_INVERSION_THR, {16'($urandom), inv});
    @(posedge clk);
  endtask

  task automatic add_beat(input int s, input logic [TIME_W-1:0] t);
    sample_beat_t b;
    b.smp = 16'(s);
    b.t_us = t;
    beat_q.push_back(b);
    gen_last = s;
    gen_now = t;
  endtask

  task automatic add_random_beat();
    int pick;
    int dir;
    int amp;
    int s;
    logic [TIME_W-1:0] dt;
    pick = $urandom_range(99, 0);
    dir = ($urandom_range(1, 0) == 1) ? 1 : -1;
    if (pick < 45) amp = (cfg_trig > 0) ? int'($urandom_range(int'(cfg_trig) - 1, 0)) : 0;
    else if (pick < 80) amp = int'(cfg_trig) + int'($urandom_range(4000, 0));
    else if (pick < 92) amp = int'(cfg_inv) + int'($urandom_range(2000, 0));
    else amp = -1;
    if (amp < 0) begin
      s = int'($urandom_range(65535, 0)) - 32768;
    end else begin
      s = gen_last + dir * amp;
      if (s > 32767 || s < -32768) s = gen_last - dir * amp;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
    end
    pick = $urandom_range(99, 0);
    if (pick < 35)
      dt = 64'(cfg_rej_us) + 64'($urandom_range((cfg_win_us > cfg_rej_us) ?
                                                 cfg_win_us - cfg_rej_us : 32'd0, 0));
    else if (pick < 55) dt = 64'($urandom_range(cfg_rej_us, 0));
    else if (pick < 75) dt = 64'(cfg_win_us) + 64'd1 + 64'($urandom_range(200000, 0));
    else if (pick < 90) dt = 64'($urandom_range(20, 0));
    else if (pick < 95) begin
      gen_now = {$urandom, $urandom};
      dt = '0;
    end else dt = -64'($urandom_range(500000, 1));
    add_beat(s, gen_now + dt);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) add_random_beat();
  endtask

  task automatic drain();
    do @(posedge clk);
    while (beat_q.size() != 0 || in_bus.valid || pending_reports.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_REJECTION_TIME;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.sample = '0;
    in_bus.time_us = '0;
    out_bus.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    add_beat(0, 64'd0);
    add_beat(100, 64'd50000);
    add_beat(32767, 64'd80000);
    add_beat(-32768, 64'd90000);
    add_beat(-32768, 64'd160000);
    add_beat(-30000, 64'd170000);
    add_beat(-27000, 64'd250000);
    add_beat(-20000, 64'd330000);
    add_beat(-20000, 64'd410000);
    add_beat(-20000, 64'd420000);
    add_beat(-20000, 64'd430000);
    add_beat(-20000, 64'd440000);
    add_beat(-10000, 64'd600000);
    add_beat(-10000, 64'd1000000);
    add_beat(-16000, 64'd1100000);
    add_beat(-16000, 64'd1500000);
    add_beat(0, 64'd1000);
    add_beat(0, 64'hFFFF_FFFF_FFFF_FFFF);
    add_beat(5000, 64'hFFFF_FFFF_FFFF_FFFF);
    add_beat(5000, 64'd69999);
    add_beat(0, 64'd100000);
    add_beat(32767, 64'h8000_0000_0000_0000);
    add_beat(-32768, 64'h8000_0000_0001_0000);
    drain();

    run_random(BEATS_PER_PHASE);
    hold_req = hold_req + 1;
    drain();

    apply_setting('0, '0, '0, '0);
    run_random(BEATS_PER_PHASE);
    drain();

    apply_setting('1, '1, '1, '1);
    run_random(BEATS_PER_PHASE);
    drain();

    apply_setting(32'd50, 32'd400, 16'd1000, 16'd1500);
    no_idle = 1'b1;
    run_random(BEATS_PER_PHASE);
    drain();
    no_idle = 1'b0;

    apply_setting(32'($urandom_range(100000, 0)), 32'($urandom_range(600000, 100000)),
                  16'($urandom_range(40000, 0)), 16'($urandom_range(65535, 0)));
    run_random(BEATS_PER_PHASE);
    drain();

    apply_setting(32'd5000, 32'd1000, 16'd300, 16'hFFFF);
    run_random(BEATS_PER_PHASE);
    drain();

    if (mismatch_cnt == 0 && pending_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
